### rtl/core/spad_pkg.sv
// Shared constants, types and stage records for the segment point block.
package spad_pkg;

   localparam int CoordWidth  = 32;
   localparam int FracBits    = 16;
   localparam int Axes        = 3;
   localparam int DistWidth   = CoordWidth - 1;
   localparam int MagWidth    = CoordWidth + 1;
   localparam int RootWidth   = MagWidth + 1;
   localparam int SumWidth    = 2 * RootWidth;
   localparam int RemWidth    = RootWidth + 2;
   localparam int ProdWidth   = RootWidth + MagWidth;
   localparam int QuoWidth    = MagWidth;
   localparam int DivRemWidth = RootWidth + 1;
   localparam int StepWidth   = CoordWidth + 2;

   localparam logic [DistWidth-1:0] DistReset = DistWidth'(64'd1 << FracBits);

   typedef enum logic {
      MODE_FROM_START = 1'b0,
      MODE_BEFORE_END = 1'b1
   } mode_type;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      logic [Axes-1:0][CoordWidth-1:0] start;
      logic [Axes-1:0][CoordWidth-1:0] finish;
      logic [Axes-1:0]                 neg;
      mode_type                        mode;
   } item_type;

   typedef struct packed {
      logic                          valid;
      item_type                      item;
      logic [Axes-1:0][MagWidth-1:0] mag;
      logic [SumWidth-1:0]           sum_rest;
      logic [RemWidth-1:0]           rem;
      logic [RootWidth-1:0]          root;
   } sqrt_stage_type;

   typedef struct packed {
      logic                             valid;
      item_type                         item;
      logic                             too_short;
      logic [RootWidth-1:0]             len;
      logic [Axes-1:0][QuoWidth-1:0]    num_rest;
      logic [Axes-1:0][DivRemWidth-1:0] rem;
      logic [Axes-1:0][QuoWidth-1:0]    quo;
   } div_stage_type;

   typedef struct packed {
      logic [Axes-1:0][CoordWidth-1:0] point;
      logic                            too_short;
   } result_type;

endpackage

### rtl/core/spad_ifs.sv
// Request and response channel interfaces.
interface spad_req_if;
   import spad_pkg::*;
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type start_z;
   coord_type end_x;
   coord_type end_y;
   coord_type end_z;
   logic      opcode;
   modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z, opcode,
                  input ready);
   modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z, opcode,
                output ready);
endinterface

interface spad_rsp_if;
   import spad_pkg::*;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;
   logic      too_short;
   modport source(output valid, point_x, point_y, point_z, too_short, input ready);
   modport sink(input valid, point_x, point_y, point_z, too_short, output ready);
endinterface

### rtl/core/spad_sqrt_cell.sv
// One root bit of the square root chain, registered.
module spad_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  spad_pkg::sqrt_stage_type stage_in,
   output spad_pkg::sqrt_stage_type stage_out
);
   import spad_pkg::*;

   logic [RemWidth-1:0] shifted;
   logic [RemWidth-1:0] trial;
   logic                ge;
   sqrt_stage_type      stage_in_nxt;
   sqrt_stage_type      stage_ff;
   logic                valid_ff;

   always_comb begin
      shifted = {stage_in.rem[RemWidth-3:0], stage_in.sum_rest[SumWidth-1 -: 2]};
      trial   = {stage_in.root, 2'b01};
      ge      = shifted >= trial;
      stage_in_nxt          = stage_in;
      stage_in_nxt.sum_rest = stage_in.sum_rest << 2;
      stage_in_nxt.rem      = ge ? shifted - trial : shifted;
      stage_in_nxt.root     = {stage_in.root[RootWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_comb begin
      stage_out       = stage_ff;
      stage_out.valid = valid_ff;
   end
endmodule

### rtl/core/spad_div_cell.sv
// One quotient bit for all three axes of the division chain, registered.
module spad_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  spad_pkg::div_stage_type stage_in,
   output spad_pkg::div_stage_type stage_out
);
   import spad_pkg::*;

   logic [Axes-1:0][DivRemWidth-1:0] shifted;
   logic [Axes-1:0]                  ge;
   div_stage_type                    stage_in_nxt;
   div_stage_type                    stage_ff;
   logic                             valid_ff;

   always_comb begin
      stage_in_nxt = stage_in;
      for (int k = 0; k < Axes; k++) begin
         shifted[k] = {stage_in.rem[k][DivRemWidth-2:0], stage_in.num_rest[k][QuoWidth-1]};
         ge[k]      = shifted[k] >= {1'b0, stage_in.len};
         stage_in_nxt.rem[k]      = ge[k] ? shifted[k] - {1'b0, stage_in.len} : shifted[k];
         stage_in_nxt.quo[k]      = {stage_in.quo[k][QuoWidth-2:0], ge[k]};
         stage_in_nxt.num_rest[k] = stage_in.num_rest[k] << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_comb begin
      stage_out       = stage_ff;
      stage_out.valid = valid_ff;
   end
endmodule

### rtl/core/segment_point_at_distance.sv
// Top level: point on a 3D segment at a set distance from start or before end.
// Fully pipelined: one item per cycle unless stalled. Each request passes the
// front, difference, squares and sum stages, one stage per root bit in the
// 34-cell square root chain, distance and product stages, one stage per
// quotient bit in the 33-cell division chain, then the output register.
// A skid register behind the output keeps requests flowing while a response
// waits; the whole chain stalls only once both are full.
module segment_point_at_distance (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [spad_pkg::DistWidth-1:0] csr_write_data,
   spad_req_if.sink                       req_ch,
   spad_rsp_if.source                     rsp_ch
);
   import spad_pkg::*;

   logic                 adv;
   logic [DistWidth-1:0] dist_ff;

   item_type                        front_ff;
   logic                            front_valid_ff;
   item_type                        diff_ff;
   logic [Axes-1:0][MagWidth-1:0]   diff_mag_ff;
   logic                            diff_valid_ff;
   item_type                        sqr_ff;
   logic [Axes-1:0][MagWidth-1:0]   sqr_mag_ff;
   logic [Axes-1:0][2*MagWidth-1:0] sqr_val_ff;
   logic                            sqr_valid_ff;
   sqrt_stage_type                  sq_head_ff;
   logic                            sq_head_valid_ff;
   sqrt_stage_type                  sq [RootWidth+1];

   item_type                        tst_ff;
   logic [Axes-1:0][MagWidth-1:0]   tst_mag_ff;
   logic [RootWidth-1:0]            tst_len_ff;
   logic [RootWidth-1:0]            tst_t_ff;
   logic                            tst_short_ff;
   logic                            tst_valid_ff;
   logic                            len_short;

   div_stage_type                   dv_head_ff;
   logic                            dv_head_valid_ff;
   logic [Axes-1:0][ProdWidth-1:0]  prod;
   div_stage_type                   dv [QuoWidth+1];

   logic signed [MagWidth-1:0]      diff [Axes];
   result_type                      final_res;
   logic [QuoWidth:0]               qr;
   logic signed [StepWidth-1:0]     step;
   logic signed [StepWidth-1:0]     sum_pt;
   div_stage_type                   last;

   result_type                      out_ff;
   logic                            out_valid_ff;
   result_type                      skid_ff;
   logic                            skid_valid_ff;
   logic                            take;

   assign adv          = !skid_valid_ff;
   assign req_ch.ready = adv;
   assign take         = out_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DistReset;
      end else if (csr_write_enable) begin
         dist_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff   <= 1'b0;
         diff_valid_ff    <= 1'b0;
         sqr_valid_ff     <= 1'b0;
         sq_head_valid_ff <= 1'b0;
         tst_valid_ff     <= 1'b0;
         dv_head_valid_ff <= 1'b0;
      end else if (adv) begin
         front_valid_ff   <= req_ch.valid;
         diff_valid_ff    <= front_valid_ff;
         sqr_valid_ff     <= diff_valid_ff;
         sq_head_valid_ff <= sqr_valid_ff;
         tst_valid_ff     <= sq[RootWidth].valid;
         dv_head_valid_ff <= tst_valid_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < Axes; k++) begin
         diff[k] = $signed({front_ff.finish[k][CoordWidth-1], front_ff.finish[k]})
                 - $signed({front_ff.start[k][CoordWidth-1], front_ff.start[k]});
      end
   end

   assign len_short = sq[RootWidth].root < RootWidth'(dist_ff);

   always_comb begin
      for (int k = 0; k < Axes; k++) begin
         prod[k] = ProdWidth'(tst_t_ff) * ProdWidth'(tst_mag_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_ff.start  <= {req_ch.start_z, req_ch.start_y, req_ch.start_x};
         front_ff.finish <= {req_ch.end_z, req_ch.end_y, req_ch.end_x};
         front_ff.neg    <= '0;
         front_ff.mode   <= mode_type'(req_ch.opcode);

         diff_ff.start  <= front_ff.start;
         diff_ff.finish <= front_ff.finish;
         diff_ff.mode   <= front_ff.mode;
         for (int k = 0; k < Axes; k++) begin
            diff_ff.neg[k] <= diff[k][MagWidth-1];
            diff_mag_ff[k] <= diff[k][MagWidth-1] ? MagWidth'(-diff[k]) : MagWidth'(diff[k]);
         end

         sqr_ff     <= diff_ff;
         sqr_mag_ff <= diff_mag_ff;
         for (int k = 0; k < Axes; k++) begin
            sqr_val_ff[k] <= (2*MagWidth)'(diff_mag_ff[k]) * (2*MagWidth)'(diff_mag_ff[k]);
         end

         sq_head_ff.valid    <= 1'b0;
         sq_head_ff.item     <= sqr_ff;
         sq_head_ff.mag      <= sqr_mag_ff;
         sq_head_ff.sum_rest <= SumWidth'(sqr_val_ff[0]) + SumWidth'(sqr_val_ff[1])
                              + SumWidth'(sqr_val_ff[2]);
         sq_head_ff.rem      <= '0;
         sq_head_ff.root     <= '0;

         tst_ff       <= sq[RootWidth].item;
         tst_mag_ff   <= sq[RootWidth].mag;
         tst_len_ff   <= sq[RootWidth].root;
         tst_short_ff <= len_short;
         tst_t_ff     <= (sq[RootWidth].item.mode == MODE_BEFORE_END)
                       ? sq[RootWidth].root - RootWidth'(dist_ff) : RootWidth'(dist_ff);

         dv_head_ff.valid     <= 1'b0;
         dv_head_ff.item      <= tst_ff;
         dv_head_ff.too_short <= tst_short_ff;
         dv_head_ff.len       <= tst_len_ff;
         for (int k = 0; k < Axes; k++) begin
            dv_head_ff.num_rest[k] <= prod[k][QuoWidth-1:0];
            dv_head_ff.rem[k]      <= DivRemWidth'(prod[k][ProdWidth-1:QuoWidth]);
            dv_head_ff.quo[k]      <= '0;
         end
      end
   end

   always_comb begin
      sq[0]       = sq_head_ff;
      sq[0].valid = sq_head_valid_ff;
      dv[0]       = dv_head_ff;
      dv[0].valid = dv_head_valid_ff;
   end

   for (genvar i = 0; i < RootWidth; i++) begin : g_sqrt
      spad_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .stage_in (sq[i]),
         .stage_out(sq[i+1])
      );
   end

   for (genvar i = 0; i < QuoWidth; i++) begin : g_div
      spad_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .stage_in (dv[i]),
         .stage_out(dv[i+1])
      );
   end

   // round half up, apply sign, add start, saturate; a too-short segment gives start or end
   always_comb begin
      last      = dv[QuoWidth];
      final_res = '0;
      qr        = '0;
      step      = '0;
      sum_pt    = '0;
      final_res.too_short = last.too_short;
      for (int k = 0; k < Axes; k++) begin
         qr = {1'b0, last.quo[k]}
            + (QuoWidth+1)'({last.rem[k], 1'b0} >= {2'b00, last.len});
         if (last.len == '0) begin
            step = '0;
         end else if (last.item.neg[k]) begin
            step = -$signed(StepWidth'(qr));
         end else begin
            step = $signed(StepWidth'(qr));
         end
         sum_pt = $signed({{(StepWidth-CoordWidth){last.item.start[k][CoordWidth-1]}},
                           last.item.start[k]}) + step;
         if (last.too_short) begin
            final_res.point[k] = (last.item.mode == MODE_BEFORE_END)
                               ? last.item.finish[k] : last.item.start[k];
         end else if (sum_pt > $signed(StepWidth'({1'b0, {(CoordWidth-1){1'b1}}}))) begin
            final_res.point[k] = {1'b0, {(CoordWidth-1){1'b1}}};
         end else if (sum_pt < -$signed(StepWidth'({1'b1, {(CoordWidth-1){1'b0}}}))) begin
            final_res.point[k] = {1'b1, {(CoordWidth-1){1'b0}}};
         end else begin
            final_res.point[k] = sum_pt[CoordWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= last.valid;
         end
      end else if (last.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_ff <= skid_valid_ff ? skid_ff : final_res;
      end else if (adv && last.valid) begin
         skid_ff <= final_res;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.point_x   = out_ff.point[0];
   assign rsp_ch.point_y   = out_ff.point[1];
   assign rsp_ch.point_z   = out_ff.point[2];
   assign rsp_ch.too_short = out_ff.too_short;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while output is empty");

   a_skid_blocks_req: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !req_ch.ready)
      else $error("request taken while skid is full");

   a_mode0_step: assert property (@(posedge clock) disable iff (reset)
      (tst_valid_ff && tst_ff.mode == MODE_FROM_START) |-> tst_t_ff == RootWidth'(dist_ff))
      else $error("forward step differs from configured distance");

   a_short_len: assert property (@(posedge clock) disable iff (reset)
      (tst_valid_ff && !tst_short_ff) |-> tst_len_ff >= RootWidth'(dist_ff))
      else $error("length below distance not flagged");
endmodule

### tb/segment_point_at_distance_test.sv
// Testbench for segment_point_at_distance: directed and random segments checked against a predictor.
`timescale 1ns / 1ps

module segment_point_at_distance_test;
   import spad_pkg::*;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      too_short;
   } point_type;

   localparam int CycleLimit = 600000;
   localparam int DrainCycles = 90;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [DistWidth-1:0] csr_write_data = '0;

   spad_req_if req_ch ();
   spad_rsp_if rsp_ch ();

   segment_point_at_distance dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #1 clock = ~clock;

   logic [DistWidth-1:0] distance = DistReset;
   point_type pending_points[$];
   int errors = 0;
   int cycles = 0;
   bit idle_enable = 1'b1;
   int rx_hold = 0;
   int rx_burst = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.start_x = '0;
      req_ch.start_y = '0;
      req_ch.start_z = '0;
      req_ch.end_x = '0;
      req_ch.end_y = '0;
      req_ch.end_z = '0;
      req_ch.opcode = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   function automatic point_type predict_point(coord_type s[3], coord_type e[3], logic mode,
                                               logic [DistWidth-1:0] d);
      point_type res;
      longint dv[3];
      logic [127:0] mag[3];
      logic [127:0] sq, root, rem, trial, len, t, n, q, r;
      longint p[3];
      coord_type o[3];
      sq = '0;
      for (int k = 0; k < 3; k++) begin
         dv[k] = longint'(e[k]) - longint'(s[k]);
         mag[k] = (dv[k] < 0) ? 128'(-dv[k]) : 128'(dv[k]);
         sq += mag[k] * mag[k];
      end
      root = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | ((sq >> (2 * i)) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      len = root;
      if (len < 128'(d)) begin
         for (int k = 0; k < 3; k++) o[k] = mode ? e[k] : s[k];
         res.too_short = 1'b1;
      end else begin
         t = (mode == MODE_BEFORE_END) ? len - 128'(d) : 128'(d);
         for (int k = 0; k < 3; k++) begin
            q = '0;
            if (len != 0) begin
               n = t * mag[k];
               q = n / len;
               r = n % len;
               if (r >= len - r) q++;
            end
            p[k] = longint'(s[k]) + ((dv[k] < 0) ? -longint'(q) : longint'(q));
            if (p[k] > 64'sd2147483647) p[k] = 64'sd2147483647;
            if (p[k] < -64'sd2147483648) p[k] = -64'sd2147483648;
            o[k] = p[k][31:0];
         end
         res.too_short = 1'b0;
      end
      res.x = o[0];
      res.y = o[1];
      res.z = o[2];
      return res;
   endfunction

   // one item; after acceptance valid stays high unless a random idle gap drops it, caller may lower it
   task automatic send_segment(coord_type sx, coord_type sy, coord_type sz,
                               coord_type ex, coord_type ey, coord_type ez, logic op);
      coord_type s[3];
      coord_type e[3];
      int gap;
      s = '{sx, sy, sz};
      e = '{ex, ey, ez};
      req_ch.start_x = sx;
      req_ch.start_y = sy;
      req_ch.start_z = sz;
      req_ch.end_x = ex;
      req_ch.end_y = ey;
      req_ch.end_z = ez;
      req_ch.opcode = op;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_points = {pending_points, predict_point(s, e, op, distance)};
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         gap = $urandom_range(1, 7);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_pipe();
      req_ch.valid = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_distance(logic [DistWidth-1:0] value);
      drain_pipe();
      csr_write_data = value;
      csr_write_enable = 1'b1;
      distance = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 4))
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom) >>> $urandom_range(8, 30));
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return coord_type'($signed($urandom) >>> 14);
      endcase
   endfunction

   function automatic coord_type near_coord(coord_type base);
      longint v;
      v = longint'(base) + (longint'($signed($urandom)) >>> $urandom_range(4, 31));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   task automatic send_random_segment();
      coord_type s[3];
      coord_type e[3];
      for (int k = 0; k < 3; k++) begin
         s[k] = rand_coord();
         e[k] = ($urandom_range(0, 2) == 0) ? rand_coord() : near_coord(s[k]);
      end
      if ($urandom_range(0, 15) == 0) e = s;
      send_segment(s[0], s[1], s[2], e[0], e[1], e[2], 1'($urandom));
   endtask

   task automatic test_directed();
      coord_type mx = 32'sh7fffffff;
      coord_type mn = 32'sh80000000;
      for (int op = 0; op < 2; op++) begin
         send_segment(mn, mn, mn, mx, mx, mx, 1'(op));
         send_segment(mx, mx, mx, mn, mn, mn, 1'(op));
         send_segment(0, 0, 0, 32'sh30000, 0, 0, 1'(op));
         send_segment(0, 0, 0, 32'sh8000, 0, 0, 1'(op));
         send_segment(5, 5, 5, 5, 5, 5, 1'(op));
         send_segment(mx, mn, 0, mn, mx, -1, 1'(op));
         send_segment(0, 0, 0, 32'sh10000, 0, 0, 1'(op));
      end
      write_distance('0);
      send_segment(7, -7, 3, 7, -7, 3, MODE_FROM_START);
      send_segment(7, -7, 3, 7, -7, 3, MODE_BEFORE_END);
      send_segment(0, 0, 0, 1, 1, 1, MODE_BEFORE_END);
      write_distance('1);
      send_segment(mn, mn, mn, mx, mx, mx, MODE_FROM_START);
      send_segment(mn, mn, mn, mx, mx, mx, MODE_BEFORE_END);
      send_segment(0, 0, 0, mx, 0, 0, MODE_BEFORE_END);
      send_segment(mn, 0, 0, mx, 0, 0, MODE_BEFORE_END);
   endtask

   task automatic test_random(int count);
      logic [DistWidth-1:0] settings[5];
      settings = '{DistReset, '0, '1, 31'h0000_0001, 31'h0123_4567};
      foreach (settings[i]) begin
         write_distance(settings[i]);
         repeat (count / 5) send_random_segment();
      end
      write_distance(DistWidth'($urandom));
      repeat (count / 10) send_random_segment();
   endtask

   task automatic test_backpressure();
      write_distance(DistReset);
      idle_enable = 1'b0;
      rx_hold = 250;
      repeat (180) send_random_segment();
      idle_enable = 1'b1;
   endtask

   task automatic test_pause();
      repeat (40) send_random_segment();
      req_ch.valid = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (40) send_random_segment();
   endtask

   task automatic test_full_rate();
      idle_enable = 1'b0;
      repeat (200) send_random_segment();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready = 1'b0;
      end else if (rx_hold > 0) begin
         rsp_ch.ready = 1'b0;
         rx_hold--;
      end else if (rx_burst > 0) begin
         rsp_ch.ready = 1'b0;
         rx_burst--;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready = 1'b0;
         rx_burst = $urandom_range(0, 6);
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected item x=%h y=%h z=%h short=%b", $time, rsp_ch.point_x,
                     rsp_ch.point_y, rsp_ch.point_z, rsp_ch.too_short);
            errors++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_ch.point_x !== want.x || rsp_ch.point_y !== want.y ||
                rsp_ch.point_z !== want.z || rsp_ch.too_short !== want.too_short) begin
               $display("%0t: mismatch expected x=%h y=%h z=%h short=%b actual x=%h y=%h z=%h short=%b",
                        $time, want.x, want.y, want.z, want.too_short, rsp_ch.point_x,
                        rsp_ch.point_y, rsp_ch.point_z, rsp_ch.too_short);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("segment_point_at_distance verification failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(1300);
      test_backpressure();
      test_pause();
      test_full_rate();
      drain_pipe();
      if (errors == 0) begin
         $display("segment_point_at_distance verification clean");
      end else begin
         $display("segment_point_at_distance verification failed");
      end
      $finish;
   end

endmodule
